// ===== sv/lph_pkg.sv =====
// Shared types and constants of the linear probing max-value hash table.
package lph_pkg;

    // Payload widths of the transaction fields and the default table size
    localparam int KEY_W          = 16;
    localparam int VALUE_W        = 16;
    localparam int TABLE_SIZE_DEF = 1024;

    // Operation codes
    localparam logic OP_UPSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // Request payload
    typedef struct packed {
        logic               operation;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_req;

    // Response payload
    typedef struct packed {
        logic               status;
        logic               found;
        logic [KEY_W-1:0]   worst_key;
        logic [VALUE_W-1:0] worst_value;
    } t_rsp;

    // One slot of the table memory
    typedef struct packed {
        logic               used;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_slot;

endpackage

// ===== sv/lph_req_if.sv =====
// Request channel: valid/ready handshake with operation, key and value.
interface lph_req_if;
    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic [lph_pkg::KEY_W-1:0]   key;
    logic [lph_pkg::VALUE_W-1:0] value;

    modport source (output valid, output operation, output key, output value, input ready);
    modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

// ===== sv/lph_rsp_if.sv =====
// Response channel: valid/ready handshake with status and largest entry.
interface lph_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic                        found;
    logic [lph_pkg::KEY_W-1:0]   worst_key;
    logic [lph_pkg::VALUE_W-1:0] worst_value;

    modport source (output valid, output status, output found, output worst_key,
                    output worst_value, input ready);
    modport sink   (input valid, input status, input found, input worst_key,
                    input worst_value, output ready);
endinterface

// ===== sv/lph_mem.sv =====
// Slot memory: one write port, one read port with registered read data.
module lph_mem #(
    parameter int TABLE_SIZE = lph_pkg::TABLE_SIZE_DEF,
    parameter int IDX_W      = $clog2(TABLE_SIZE)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [IDX_W-1:0]     i_waddr,
    input  lph_pkg::t_slot       i_wdata,
    input  logic [IDX_W-1:0]     i_raddr,
    output lph_pkg::t_slot       o_rdata
);

    lph_pkg::t_slot r_mem [TABLE_SIZE];
    lph_pkg::t_slot r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/lph_ctrl.sv =====
// Sequencer: clearing sweep, key remainder, linear probe and max scan.
module lph_ctrl #(
    parameter int TABLE_SIZE = lph_pkg::TABLE_SIZE_DEF,
    parameter int IDX_W      = $clog2(TABLE_SIZE)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  lph_pkg::t_req        i_req,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output lph_pkg::t_rsp        o_res,
    output logic                 o_mem_we,
    output logic [IDX_W-1:0]     o_mem_waddr,
    output lph_pkg::t_slot       o_mem_wdata,
    output logic [IDX_W-1:0]     o_mem_raddr,
    input  lph_pkg::t_slot       i_mem_rdata
);

    localparam int PROD_W = lph_pkg::KEY_W + 32;
    localparam bit POW2   = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    // Reciprocal of the table size, scaled by 2^32
    localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(TABLE_SIZE));
    localparam logic [lph_pkg::KEY_W-1:0] TS_KEY = (lph_pkg::KEY_W)'(TABLE_SIZE);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_SUB,
        S_FIX,
        S_ISSUE,
        S_PROBE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic [IDX_W-1:0]              r_idx;
    logic [IDX_W-1:0]              r_cnt;
    logic [lph_pkg::KEY_W-1:0]     r_quot;
    logic [lph_pkg::KEY_W-1:0]     r_rem;
    logic                          r_op;
    logic [lph_pkg::KEY_W-1:0]     r_key;
    logic [lph_pkg::VALUE_W-1:0]   r_val;
    logic                          r_full;
    logic                          r_any;
    logic [lph_pkg::KEY_W-1:0]     r_best_key;
    logic [lph_pkg::VALUE_W-1:0]   r_best_val;

    logic [IDX_W-1:0]              idx_next;
    logic [lph_pkg::KEY_W-1:0]     quot_est;
    logic [lph_pkg::KEY_W-1:0]     rem_est;
    logic [lph_pkg::KEY_W-1:0]     rem_fix;
    logic                          probe_hit;
    logic                          scan_take;

    // Wrap the probe index at the end of the table
    assign idx_next = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;

    // Key modulo table size: the reciprocal estimate of the quotient is low
    // by at most one, so one compare and subtract finishes the remainder
    assign quot_est = (lph_pkg::KEY_W)'((PROD_W'(r_key) * PROD_W'(RECIP)) >> 32);
    assign rem_est  = r_key - r_quot * TS_KEY;
    assign rem_fix  = (r_rem >= TS_KEY) ? r_rem - TS_KEY : r_rem;

    // Compare logic: free or matching slot on probe, larger value on scan
    assign probe_hit = !i_mem_rdata.used || (i_mem_rdata.key == r_key);
    assign scan_take = i_mem_rdata.used && (!r_any || (i_mem_rdata.value > r_best_val));

    // Drive the memory ports
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx;
        o_mem_wdata = '{used: 1'b1, key: r_key, value: r_val};
        o_mem_raddr = r_idx;
        unique case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = '{used: 1'b0, key: '0, value: '0};
            end
            S_PROBE: begin
                o_mem_raddr = idx_next;
                o_mem_we    = probe_hit;
            end
            S_SCAN: begin
                o_mem_raddr = idx_next;
            end
            default: begin
            end
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = '{status: r_full, found: r_any,
                           worst_key: r_best_key, worst_value: r_best_val};

    // Sequencer state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_op       <= i_req.operation;
                        r_key      <= i_req.key;
                        r_val      <= i_req.value;
                        r_full     <= lph_pkg::ST_OK;
                        r_any      <= 1'b0;
                        r_best_key <= '0;
                        r_best_val <= '0;
                        r_cnt      <= '0;
                        if (i_req.operation == lph_pkg::OP_QUERY) begin
                            r_idx   <= '0;
                            r_state <= S_ISSUE;
                        end else if (POW2) begin
                            r_idx   <= i_req.key[IDX_W-1:0];
                            r_state <= S_ISSUE;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_quot  <= quot_est;
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_rem   <= rem_est;
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    r_idx   <= rem_fix[IDX_W-1:0];
                    r_state <= S_ISSUE;
                end
                S_ISSUE: begin
                    r_state <= (r_op == lph_pkg::OP_QUERY) ? S_SCAN : S_PROBE;
                end
                S_PROBE: begin
                    if (probe_hit) begin
                        r_state <= S_DONE;
                    end else if (r_cnt == LAST_IDX) begin
                        r_full  <= lph_pkg::ST_FULL;
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= idx_next;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SCAN: begin
                    if (scan_take) begin
                        r_any      <= 1'b1;
                        r_best_key <= i_mem_rdata.key;
                        r_best_val <= i_mem_rdata.value;
                    end
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= idx_next;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // No table write while waiting for a transaction
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_mem_we)
        else $error("table written while idle");

    // An accepted transaction blocks the next one
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("request accepted back to back");

    // Read address stays inside the table
    a_raddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_raddr <= LAST_IDX)
        else $error("read address beyond table");

    // A full status never comes with a found entry
    a_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_res.status && o_res.found))
        else $error("full status on a query result");

endmodule

// ===== sv/linear_probe_hash_max_table_core.sv =====
// Top level of the linear probing hash table with largest-value query.
//
// Request channel i_req carries operation, key and value; response channel
// o_rsp returns status, found, worst_key and worst_value, one response per
// request, in order. Both use valid/ready; a transaction moves when both
// are high at a rising edge of i_clk.
// An upsert hashes the key (key mod TABLE_SIZE, a mask for a power of two,
// otherwise a reciprocal multiply and one correcting subtract), then probes
// one slot per cycle through the single read port of the slot memory. A full
// table costs TABLE_SIZE probes and returns status full. A query reads every
// slot once. One request is worked on at a time; i_req.ready is high only
// while idle. Results go into an output register, so a stalled receiver
// holds the response there while the next request is taken and worked on;
// that one then waits and no further request is taken.
// After reset the used marks are swept clear, one slot per cycle, and no
// request is accepted during the sweep.
module linear_probe_hash_max_table_core #(
    parameter int TABLE_SIZE = lph_pkg::TABLE_SIZE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lph_req_if.sink       i_req,
    lph_rsp_if.source     o_rsp
);

    localparam int IDX_W = $clog2(TABLE_SIZE);

    lph_pkg::t_req    req;
    lph_pkg::t_rsp    res;
    logic             res_valid;
    logic             res_ready;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    lph_pkg::t_slot   mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    lph_pkg::t_slot   mem_rdata;

    logic             r_out_valid;
    lph_pkg::t_rsp    r_out;

    assign req = '{operation: i_req.operation, key: i_req.key, value: i_req.value};

    lph_ctrl #(
        .TABLE_SIZE (TABLE_SIZE),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    lph_mem #(
        .TABLE_SIZE (TABLE_SIZE),
        .IDX_W      (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Take a result when the output register is empty or draining
    assign res_ready = !r_out_valid || o_rsp.ready;

    // Hold the response until the receiver takes the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the response payload
    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.found       = r_out.found;
    assign o_rsp.worst_key   = r_out.worst_key;
    assign o_rsp.worst_value = r_out.worst_value;

endmodule

// ===== dv/tb_linear_probe_hash_max_table_core.sv =====
// Testbench for the linear probing hash table with largest-value query.
module tb_linear_probe_hash_max_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lph_pkg::*;

    localparam int SLOTS       = TABLE_SIZE_DEF;
    localparam int KEY_SPAN    = (1 << KEY_W) / SLOTS;
    localparam int N_RANDOM    = 300;
    localparam int N_FULL      = 30;
    localparam int N_HOT       = 16;
    // Worst case: ~1250 transactions, each a full scan plus the longest gap and
    // stall, plus the clearing sweep and the forced hold-offs, taken ~3x.
    localparam int CYCLE_LIMIT = 4_000_000;

    // Shadow copy of the table: predicts each response and checks it in order
    class table_shadow;
        logic [KEY_W-1:0]   slot_key [SLOTS];
        logic [VALUE_W-1:0] slot_value [SLOTS];
        bit                 slot_used [SLOTS];
        t_rsp               expected_rsp [$];
        int                 n_errors;
        int                 n_upserts;
        int                 n_dropped;
        int                 n_queries;
        int                 n_checked;

        function new();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        endfunction

        // Probe from the home slot; overwrite the key or fill the first free slot
        function logic upsert(input logic [KEY_W-1:0] key, input logic [VALUE_W-1:0] value);
            int idx;
            idx = int'(key) % SLOTS;
            for (int n = 0; n < SLOTS; n++) begin
                if (!slot_used[idx] || slot_key[idx] == key) begin
                    slot_key[idx]   = key;
                    slot_value[idx] = value;
                    slot_used[idx]  = 1'b1;
                    return ST_OK;
                end
                idx = (idx + 1) % SLOTS;
            end
            return ST_FULL;
        endfunction

        // Scan in index order; strict compare keeps the lowest index on ties
        function t_rsp largest_entry();
            t_rsp res;
            res = '0;
            res.status = ST_OK;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_used[i] && (!res.found || slot_value[i] > res.worst_value)) begin
                    res.found       = 1'b1;
                    res.worst_key   = slot_key[i];
                    res.worst_value = slot_value[i];
                end
            end
            return res;
        endfunction

        function void take_request(input t_req item);
            t_rsp res;
            res = '0;
            if (item.operation == OP_UPSERT) begin
                res.status = upsert(item.key, item.value);
                n_upserts++;
                if (res.status == ST_FULL) n_dropped++;
            end else begin
                res = largest_entry();
                n_queries++;
            end
            expected_rsp.push_back(res);
        endfunction

        function void check_response(input t_rsp got);
            t_rsp want;
            if (expected_rsp.size() == 0) begin
                $error("response with nothing pending: status %0d found %0d key %0h value %0h",
                       got.status, got.found, got.worst_key, got.worst_value);
                n_errors++;
                return;
            end
            want = expected_rsp.pop_front();
            n_checked++;
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                n_errors++;
            end
            if (got.found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                n_errors++;
            end
            if (got.worst_key !== want.worst_key) begin
                $error("worst_key: expected %0h, got %0h", want.worst_key, got.worst_key);
                n_errors++;
            end
            if (got.worst_value !== want.worst_value) begin
                $error("worst_value: expected %0h, got %0h", want.worst_value, got.worst_value);
                n_errors++;
            end
        endfunction

        function int used_count();
            int cnt;
            cnt = 0;
            foreach (slot_used[i]) cnt += slot_used[i];
            return cnt;
        endfunction

        function bit holds_key(input logic [KEY_W-1:0] key);
            foreach (slot_used[i]) if (slot_used[i] && slot_key[i] == key) return 1'b1;
            return 1'b0;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    int          cycle_count;
    int          n_sent;
    int          hold_left;
    int          idle_left;
    logic [KEY_W-1:0] hot_keys [N_HOT];
    table_shadow shadow;

    lph_req_if req_ch();
    lph_rsp_if rsp_ch();

    linear_probe_hash_max_table_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Free-running clock
    always #5 clk = ~clk;

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sender runs back to back in every fourth stretch of 64 transactions
    function automatic int sender_gap();
        if ((n_sent / 64) % 4 == 3) return 0;
        return pick_gap();
    endfunction

    function automatic t_req make_upsert(input logic [KEY_W-1:0] key,
                                         input logic [VALUE_W-1:0] value);
        t_req item;
        item.operation = OP_UPSERT;
        item.key       = key;
        item.value     = value;
        return item;
    endfunction

    // Query fields key and value are don't-care, so fill them with noise
    function automatic t_req make_query();
        t_req item;
        item.operation = OP_QUERY;
        item.key       = KEY_W'($urandom);
        item.value     = VALUE_W'($urandom);
        return item;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return VALUE_W'($urandom);
    endfunction

    // Hot keys overwrite, crowded homes build chains and wrap, the rest spread out
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        int home;
        r = $urandom_range(0, 99);
        if (r < 30) return hot_keys[$urandom_range(0, N_HOT - 1)];
        if (r < 55) begin
            case ($urandom_range(0, 3))
                0: home = $urandom_range(0, 2);
                1: home = SLOTS - 1 - $urandom_range(0, 3);
                2: home = SLOTS / 2;
                default: home = $urandom_range(0, SLOTS - 1);
            endcase
            return KEY_W'($urandom_range(0, KEY_SPAN - 1) * SLOTS + home);
        end
        return KEY_W'($urandom);
    endfunction

    // Hold idle for the gap, then offer the transaction until it is taken
    task automatic send_request(input t_req item);
        int gap;
        gap = sender_gap();
        repeat (gap) begin
            @(negedge clk);
            req_ch.valid     <= 1'b0;
            req_ch.operation <= 1'($urandom);
            req_ch.key       <= KEY_W'($urandom);
            req_ch.value     <= VALUE_W'($urandom);
        end
        @(negedge clk);
        req_ch.valid     <= 1'b1;
        req_ch.operation <= item.operation;
        req_ch.key       <= item.key;
        req_ch.value     <= item.value;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        shadow.take_request(item);
        n_sent++;
    endtask

    // Receiver: random stalls, steady stretches, and two long hold-offs
    initial begin
        rsp_ch.ready = 1'b0;
        hold_left    = 0;
        idle_left    = 0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end else if (idle_left > 0) begin
                rsp_ch.ready <= 1'b0;
                idle_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
                shadow.check_response('{status:      rsp_ch.status,
                                        found:       rsp_ch.found,
                                        worst_key:   rsp_ch.worst_key,
                                        worst_value: rsp_ch.worst_value});
                if (shadow.n_checked == 40 || shadow.n_checked == 700)
                    hold_left = 400;
                else if ((shadow.n_checked / 100) % 3 != 2)
                    idle_left = pick_gap();
            end else if ($urandom_range(0, 15) == 0 && (shadow.n_checked / 100) % 3 != 2) begin
                idle_left = pick_gap();
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count += 1;
        end
        $error("timeout after %0d cycles, %0d responses still pending",
               cycle_count, shadow.expected_rsp.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Main sequence
    initial begin
        int slot;
        logic [KEY_W-1:0] key;

        clk              = 1'b0;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_UPSERT;
        req_ch.key       = '0;
        req_ch.value     = '0;
        n_sent           = 0;
        shadow           = new();
        foreach (hot_keys[i]) hot_keys[i] = KEY_W'($urandom);

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, extremes, wrap at the end, overwrites and ties
        send_request(make_query());
        send_request(make_upsert(16'h0000, 16'h0000));
        send_request(make_query());
        send_request(make_upsert(16'hFFFF, 16'hFFFF));
        send_request(make_upsert(KEY_W'(SLOTS - 1), 16'd100));
        send_request(make_upsert(KEY_W'(SLOTS), 16'hFFFF));
        send_request(make_query());
        send_request(make_upsert(16'hFFFF, 16'd5));
        send_request(make_query());
        send_request(make_upsert(KEY_W'(SLOTS), 16'h8000));
        send_request(make_upsert(16'd3, 16'h8000));
        send_request(make_query());
        send_request(make_upsert(16'h5555, 16'h7FFF));
        send_request(make_upsert(16'hAAAA, 16'h0001));
        send_request(make_upsert(16'd3, 16'h0000));
        send_request(make_query());

        // Random mix on a partly filled table
        repeat (N_RANDOM) begin
            if ($urandom_range(0, 11) == 0)
                send_request(make_query());
            else
                send_request(make_upsert(pick_key(), pick_value()));
        end

        // Fill every free slot with a fresh key homed there, plus some noise
        while (shadow.used_count() < SLOTS) begin
            case ($urandom_range(0, 59))
                0: send_request(make_query());
                1, 2: send_request(make_upsert(hot_keys[$urandom_range(0, N_HOT - 1)],
                                               pick_value()));
                default: begin
                    slot = $urandom_range(0, SLOTS - 1);
                    while (shadow.slot_used[slot]) slot = (slot + 1) % SLOTS;
                    do begin
                        key = KEY_W'($urandom_range(0, KEY_SPAN - 1) * SLOTS + slot);
                    end while (shadow.holds_key(key));
                    send_request(make_upsert(key, pick_value()));
                end
            endcase
        end

        // Full table: new keys are dropped, present keys still update
        send_request(make_upsert(16'hFFFF, 16'h1234));
        repeat (N_FULL) begin
            case ($urandom_range(0, 2))
                0: begin
                    do key = KEY_W'($urandom); while (shadow.holds_key(key));
                    send_request(make_upsert(key, pick_value()));
                end
                1: send_request(make_upsert(shadow.slot_key[$urandom_range(0, SLOTS - 1)],
                                            pick_value()));
                default: send_request(make_query());
            endcase
        end
        send_request(make_query());

        @(negedge clk);
        req_ch.valid <= 1'b0;

        // Drain, then allow one full scan for any stray response
        while (shadow.expected_rsp.size() != 0) @(posedge clk);
        repeat (SLOTS + 50) @(posedge clk);

        $display("Ran %0d upserts (%0d dropped on a full table) and %0d queries",
                 shadow.n_upserts, shadow.n_dropped, shadow.n_queries);
        $display("Checked %0d responses; %0d of %0d slots in use at the end",
                 shadow.n_checked, shadow.used_count(), SLOTS);
        if (shadow.n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/lph_pkg.sv
sv/lph_req_if.sv
sv/lph_rsp_if.sv
sv/lph_mem.sv
sv/lph_ctrl.sv
sv/linear_probe_hash_max_table_core.sv
dv/tb_linear_probe_hash_max_table_core.sv
